// ----- hw/rtl/sfd_pkg.sv -----
package sfd_pkg;

  // Ring geometry and sample format
  localparam int RING_DEPTH  = 65536;
  localparam int AW          = $clog2(RING_DEPTH);
  localparam int SAMPLE_BITS = 16;

  // Register widths
  localparam int DELAY_W    = 16;
  localparam int FB_W       = 15;
  localparam int MIX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Smoothed gains are unsigned Q1.23
  localparam int FRAC_Q       = 23;
  localparam int SM_W         = FRAC_Q + 1;
  localparam int UNITY_Q      = 2 ** FRAC_Q;
  localparam int TGT_SHIFT    = FRAC_Q - 15;
  localparam int GLIDE_K      = 328;
  localparam int GLIDE_SHIFT  = 16;
  localparam int FEEDBACK_MAX = 31129;
  localparam int MIX_MAX      = 32768;

  // Arithmetic widths: glide product and wide accumulator
  localparam int GP_W   = SM_W + 10;
  localparam int PROD_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_MIX      = 2'd2,
    CFG_ENABLE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_start;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_t;

  // Divide by 2^s, round to nearest, ties away from zero
  function automatic logic signed [PROD_W-1:0] rnd_shift(logic signed [PROD_W-1:0] v, int s);
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] neg;
    half = $signed(PROD_W'(1)) <<< (s - 1);
    neg  = $signed({{(PROD_W-1){1'b0}}, v[PROD_W-1]});
    return (v + half - neg) >>> s;
  endfunction

  // Clamp to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = $signed(PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1));
    lo = -hi - $signed(PROD_W'(1));
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/stereo_feedback_delay_core.sv -----
// Each input transfer passes through the read, glide, multiply and write-back steps before the result is registered.
// A new sample pair is taken only once the previous one has finished its read-modify-write of the two ring RAMs.
// Output register frees the input side: the next pair is taken while a result waits.
// Reset (async, active low): control registers cleared, enable set, write position and fill state zero;
// ring entries not yet written since the last clear read as zero through fill tracking,
// so there is no clearing pass and the block is ready right after reset.
module stereo_feedback_delay_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sfd_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sfd_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GLIDE = 4'b0010,
    S_MUL   = 4'b0100,
    S_WB    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [DELAY_W-1:0] delay_q;
  logic [FB_W-1:0]    fb_q;
  logic [MIX_W-1:0]   mix_q;
  logic               en_q;

  // Ring position and fill tracking
  logic [AW-1:0] wp_q;
  logic          wrap_q;

  // Smoothed gains, unsigned Q1.23
  logic [SM_W-1:0] sf_q, sf_d;
  logic [SM_W-1:0] sm_q, sm_d;

  // Per-item payload
  logic signed [SAMPLE_BITS-1:0] xl_q, xr_q;
  logic                          gl_q;
  logic                          rd_ok_q;
  logic signed [GP_W-1:0]        fb_gp_q, mx_gp_q;
  logic signed [SAMPLE_BITS-1:0] rdl_q, rdr_q;
  logic signed [PROD_W-1:0]      pfl_q, pfr_q, pxl_q, pxr_q, pdl_q, pdr_q;

  // Ring RAMs
  logic signed [SAMPLE_BITS-1:0] ring_l [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] ring_r [RING_DEPTH];

  logic          in_xfer, cfg_xfer, ld_out, wr_en;
  logic [AW-1:0] d_eff, rp;
  logic          rd_ok;

  logic [FB_W-1:0]         fb_clip;
  logic [MIX_W-1:0]        mix_clip;
  logic [SM_W-1:0]         fb_tgt, mx_tgt, dry;
  logic signed [SM_W:0]    fb_diff, mx_diff;
  logic signed [GP_W-1:0]  fb_gp_d, mx_gp_d;
  logic signed [SAMPLE_BITS-1:0] dl, dr, wl, wr, yl, yr;

  logic   out_valid_q;
  out_t   out_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign ld_out      = (state_q == S_WB) && (!out_valid_q || out_ready_i);
  assign wr_en       = ld_out && en_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Read address: a delay of zero or of the full ring reads the oldest entry
  always_comb begin
    if ({1'b0, delay_q} >= (DELAY_W + 1)'(RING_DEPTH)) begin
      d_eff = '0;
    end else begin
      d_eff = AW'(delay_q);
    end
    rp    = wp_q - d_eff;
    rd_ok = wrap_q || (rp < wp_q);
  end

  // Glide products from current targets and smoothed values
  always_comb begin
    fb_clip  = (fb_q > FB_W'(FEEDBACK_MAX)) ? FB_W'(FEEDBACK_MAX) : fb_q;
    mix_clip = (mix_q > MIX_W'(MIX_MAX)) ? MIX_W'(MIX_MAX) : mix_q;
    fb_tgt   = SM_W'({fb_clip, {TGT_SHIFT{1'b0}}});
    mx_tgt   = SM_W'({mix_clip, {TGT_SHIFT{1'b0}}});
    fb_diff  = $signed({1'b0, fb_tgt}) - $signed({1'b0, sf_q});
    mx_diff  = $signed({1'b0, mx_tgt}) - $signed({1'b0, sm_q});
    fb_gp_d  = GP_W'(fb_diff) * $signed(GP_W'(GLIDE_K));
    mx_gp_d  = GP_W'(mx_diff) * $signed(GP_W'(GLIDE_K));
  end

  // Apply one glide step
  always_comb begin
    sf_d = sf_q;
    sm_d = sm_q;
    if (state_q == S_GLIDE && gl_q) begin
      sf_d = SM_W'(PROD_W'($signed({1'b0, sf_q})) + rnd_shift(PROD_W'(fb_gp_q), GLIDE_SHIFT));
      sm_d = SM_W'(PROD_W'($signed({1'b0, sm_q})) + rnd_shift(PROD_W'(mx_gp_q), GLIDE_SHIFT));
    end
  end

  // Delayed samples, unwritten entries read as zero
  always_comb begin
    dl  = rd_ok_q ? rdl_q : '0;
    dr  = rd_ok_q ? rdr_q : '0;
    dry = SM_W'(UNITY_Q) - sm_q;
  end

  // Write-back values and mixed outputs
  always_comb begin
    wl = sat_sample(PROD_W'(xl_q) + rnd_shift(pfl_q, FRAC_Q));
    wr = sat_sample(PROD_W'(xr_q) + rnd_shift(pfr_q, FRAC_Q));
    yl = sat_sample(rnd_shift(pxl_q + pdl_q, FRAC_Q));
    yr = sat_sample(rnd_shift(pxr_q + pdr_q, FRAC_Q));
  end

  // Sequence one item through read, glide, multiply, write back
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_GLIDE;
      S_GLIDE: state_d = S_MUL;
      S_MUL:   state_d = S_WB;
      S_WB:    if (ld_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      delay_q     <= '0;
      fb_q        <= '0;
      mix_q       <= '0;
      en_q        <= 1'b1;
      wp_q        <= '0;
      wrap_q      <= 1'b0;
      sf_q        <= '0;
      sm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sf_q    <= sf_d;
      sm_q    <= sm_d;
      // Advance the write position after each ring write
      if (wr_en) begin
        if (wp_q == AW'(RING_DEPTH - 1)) begin
          wp_q   <= '0;
          wrap_q <= 1'b1;
        end else begin
          wp_q <= wp_q + AW'(1);
        end
      end
      // Take register writes; disabling clears the ring fill state
      if (cfg_xfer) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DELAY:    delay_q <= cfg_data_i[DELAY_W-1:0];
          CFG_FEEDBACK: fb_q    <= cfg_data_i[FB_W-1:0];
          CFG_MIX:      mix_q   <= cfg_data_i[MIX_W-1:0];
          CFG_ENABLE: begin
            en_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              wp_q   <= '0;
              wrap_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      // Hold the result until the output transfer
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      xl_q    <= in_data_i.left_in;
      xr_q    <= in_data_i.right_in;
      gl_q    <= en_q && in_data_i.block_start;
      rd_ok_q <= rd_ok;
      fb_gp_q <= fb_gp_d;
      mx_gp_q <= mx_gp_d;
    end
    if (state_q == S_MUL) begin
      pfl_q <= dl * $signed({1'b0, sf_q});
      pfr_q <= dr * $signed({1'b0, sf_q});
      pxl_q <= xl_q * $signed({1'b0, dry});
      pxr_q <= xr_q * $signed({1'b0, dry});
      pdl_q <= dl * $signed({1'b0, sm_q});
      pdr_q <= dr * $signed({1'b0, sm_q});
    end
    if (ld_out) begin
      if (en_q) begin
        out_q.left_out  <= yl;
        out_q.right_out <= yr;
      end else begin
        out_q.left_out  <= xl_q;
        out_q.right_out <= xr_q;
      end
    end
  end

  // Ring RAMs: read on input transfer, write back at the end of the item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rdl_q <= ring_l[rp];
      rdr_q <= ring_r[rp];
    end
    if (wr_en) begin
      ring_l[wp_q] <= wl;
      ring_r[wp_q] <= wr;
    end
  end

endmodule

// ----- hw/rtl/sfd_checker.sv -----
module sfd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input sfd_pkg::out_t                    out_data_o
);
  import sfd_pkg::*;

  // One item in flight: input closes right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // With no result waiting, an item yields a valid result once it has passed the glide, multiply and write-back states
  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |-> ##4 out_valid_o)
    else $error("result missing after input transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // Result withdrawn only by a transfer
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without transfer");

endmodule

bind stereo_feedback_delay_core sfd_checker u_sfd_checker (.*);

// ----- bench/stereo_feedback_delay_core_tb.sv -----
module stereo_feedback_delay_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam int     IDLE_PCT    = 22;
  localparam int     RX_HOLD_AT  = 500;
  localparam int     RX_HOLD_LEN = 300;
  localparam int     QUIET_LO    = 1000;
  localparam int     QUIET_HI    = 1300;
  localparam int     RANDOM_ITEMS = 1750;
  localparam longint GLIDE_STEP  = 328;
  localparam longint FB_CEIL     = 31129;
  localparam longint MIX_CEIL    = 32768;
  localparam longint UNITY_GAIN  = 64'sd1 <<< 23;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stereo_feedback_delay_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Pending sample pairs and expected mixed outputs
  in_t  pair_q[$];
  out_t mix_q[$];

  // Echo state mirrored from the block
  shortint     left_mem [65536];
  shortint     right_mem[65536];
  logic [15:0] wr_pos = '0;
  longint      sm_fb = 0;
  longint      sm_mix = 0;
  logic [15:0] delay_reg = '0;
  logic [14:0] fb_reg = '0;
  logic [15:0] mix_reg = '0;
  logic        echo_on = 1'b1;

  int   in_count = 0;
  int   out_count = 0;
  int   err_count = 0;
  int   cycle_count = 0;
  logic in_fired = 1'b0;
  int   rx_hold_left = 0;
  logic rx_hold_done = 1'b0;

  // Divide by 2^s, round to nearest with ties away from zero
  function automatic longint div_round(longint v, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Advance the echo state by one sample pair and return the mixed output
  function automatic out_t echo_predict(in_t x);
    longint      xl;
    longint      xr;
    longint      dl;
    longint      dr;
    longint      dry;
    longint      tgt;
    logic [15:0] rd_pos;
    out_t        y;
    xl = $signed(x.left_in);
    xr = $signed(x.right_in);
    if (!echo_on) begin
      y.left_out  = x.left_in;
      y.right_out = x.right_in;
      return y;
    end
    if (x.block_start) begin
      tgt    = ((fb_reg > FB_CEIL) ? FB_CEIL : longint'(fb_reg)) <<< 8;
      sm_fb  = sm_fb + div_round((tgt - sm_fb) * GLIDE_STEP, 16);
      tgt    = ((mix_reg > MIX_CEIL) ? MIX_CEIL : longint'(mix_reg)) <<< 8;
      sm_mix = sm_mix + div_round((tgt - sm_mix) * GLIDE_STEP, 16);
    end
    rd_pos = wr_pos - delay_reg;
    dl     = left_mem[rd_pos];
    dr     = right_mem[rd_pos];
    dry    = UNITY_GAIN - sm_mix;
    left_mem[wr_pos]  = clamp16(xl + div_round(dl * sm_fb, 23));
    right_mem[wr_pos] = clamp16(xr + div_round(dr * sm_fb, 23));
    y.left_out  = clamp16(div_round(xl * dry + dl * sm_mix, 23));
    y.right_out = clamp16(div_round(xr * dry + dr * sm_mix, 23));
    wr_pos = wr_pos + 16'd1;
    return y;
  endfunction

  // Timeout guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stereo_feedback_delay_core verification failed");
      $finish;
    end
  end

  // Input side: record each transfer and predict its output
  always @(posedge clk_i) begin
    in_fired <= in_valid && in_ready_o;
    if (in_valid && in_ready_o) begin
      mix_q.push_back(echo_predict(in_data));
      in_count++;
    end
  end

  // Input side: offer the next pair, idling at random outside the quiet window
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fired)) begin
      if (pair_q.size() != 0 &&
          (in_count >= QUIET_LO && in_count < QUIET_HI ||
           $urandom_range(99, 0) >= IDLE_PCT)) begin
        in_data  <= pair_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready) begin
      out_count++;
      if (mix_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected output expected none actual %0d/%0d", $time,
                 out_data_o.left_out, out_data_o.right_out);
      end else begin
        if (out_data_o.left_out !== mix_q[0].left_out) begin
          err_count++;
          $display("%0t: left_out expected %0d actual %0d", $time,
                   mix_q[0].left_out, out_data_o.left_out);
        end
        if (out_data_o.right_out !== mix_q[0].right_out) begin
          err_count++;
          $display("%0t: right_out expected %0d actual %0d", $time,
                   mix_q[0].right_out, out_data_o.right_out);
        end
        void'(mix_q.pop_front());
      end
    end
  end

  // Output side: random back-pressure plus one long hold while pairs are still queued
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_ready    <= 1'b0;
      end else if (!rx_hold_done && in_count >= RX_HOLD_AT && pair_q.size() != 0) begin
        rx_hold_left <= RX_HOLD_LEN;
        rx_hold_done <= 1'b1;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= (out_count >= QUIET_LO && out_count < QUIET_HI) ||
                     ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  task automatic push_pair(input logic [15:0] l, input logic [15:0] r, input logic bs);
    pair_q.push_back('{left_in: l, right_in: r, block_start: bs});
  endtask

  // Hold off until every pair is sent and every output has come back
  task automatic drain();
    while (pair_q.size() != 0 || in_valid || mix_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write one register and mirror it
  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DELAY:    delay_reg = val;
      CFG_FEEDBACK: fb_reg    = val[14:0];
      CFG_MIX:      mix_reg   = val;
      CFG_ENABLE: begin
        echo_on = val[0];
        if (!val[0]) begin
          for (int i = 0; i < 65536; i++) begin
            left_mem[i]  = 0;
            right_mem[i] = 0;
          end
          wr_pos = '0;
        end
      end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(9, 0))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return ($urandom_range(1, 0) != 0) ? 16'h0000 : 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          total;
    int          n;
    int          bs_pct;
    int          phase;
    logic [15:0] d;
    logic [15:0] f;
    logic [15:0] m;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Short delay with gains written above their ceilings
    cfg_write(CFG_DELAY, 16'd1);
    cfg_write(CFG_FEEDBACK, 16'hffff);
    cfg_write(CFG_MIX, 16'hffff);
    cfg_write(CFG_ENABLE, 16'h0001);
    push_pair(16'h7fff, 16'h8000, 1'b1);
    push_pair(16'h8000, 16'h7fff, 1'b1);
    push_pair(16'h0000, 16'h0000, 1'b1);
    push_pair(16'hffff, 16'h0001, 1'b1);
    push_pair(16'h4000, 16'hc000, 1'b1);
    push_pair(16'h7fff, 16'h7fff, 1'b1);
    push_pair(16'h8000, 16'h8000, 1'b0);
    push_pair(16'h5555, 16'haaaa, 1'b1);
    drain();

    // Zero delay reads the oldest entry
    cfg_write(CFG_DELAY, 16'd0);
    push_pair(16'h7fff, 16'h8000, 1'b1);
    push_pair(16'h1234, 16'hedcb, 1'b0);
    push_pair(16'h8000, 16'h7fff, 1'b1);
    drain();

    // Disabled: pass through, block start ignored
    cfg_write(CFG_ENABLE, 16'h0000);
    push_pair(16'h7fff, 16'h8000, 1'b1);
    push_pair(16'h8000, 16'h7fff, 1'b1);
    push_pair(16'hffff, 16'h0000, 1'b0);
    drain();

    // Disable written again clears again
    cfg_write(CFG_ENABLE, 16'hfffe);
    push_pair(16'h0001, 16'hfffe, 1'b1);
    push_pair(16'h2aaa, 16'hd555, 1'b0);
    drain();

    // Re-enable, then enable written again must keep history
    cfg_write(CFG_ENABLE, 16'h0001);
    cfg_write(CFG_DELAY, 16'd3);
    push_pair(16'h7fff, 16'h8000, 1'b1);
    push_pair(16'h6000, 16'ha000, 1'b1);
    push_pair(16'h8000, 16'h7fff, 1'b1);
    push_pair(16'h0100, 16'hff00, 1'b1);
    drain();
    cfg_write(CFG_ENABLE, 16'h0001);
    push_pair(16'h7fff, 16'h7fff, 1'b1);
    push_pair(16'h8000, 16'h8000, 1'b1);
    push_pair(16'h0000, 16'hffff, 1'b1);
    drain();

    // Random phases over many settings
    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      if (phase == 0) begin
        // Glide hard toward full feedback and full wet on a short delay
        d      = 16'($urandom_range(8, 1));
        f      = 16'd31129;
        m      = 16'd32768;
        n      = 300;
        bs_pct = 100;
      end else begin
        case ($urandom_range(7, 0))
          0:       d = 16'd0;
          1:       d = 16'd1;
          2:       d = 16'hffff;
          3:       d = 16'($urandom_range(8, 2));
          4, 5:    d = 16'($urandom_range(64, 1));
          6:       d = 16'($urandom_range(1500, 65));
          default: d = 16'($urandom);
        endcase
        case ($urandom_range(3, 0))
          0:       f = 16'($urandom);
          1:       f = 16'd31129;
          2:       f = 16'($urandom_range(65535, 31130));
          default: f = 16'($urandom_range(31129, 20000));
        endcase
        case ($urandom_range(4, 0))
          0:       m = 16'($urandom);
          1:       m = 16'd32768;
          2:       m = 16'd0;
          3:       m = 16'($urandom_range(65535, 32769));
          default: m = 16'($urandom_range(32768, 16000));
        endcase
        n = $urandom_range(160, 90);
        case ($urandom_range(2, 0))
          0:       bs_pct = 10;
          1:       bs_pct = 50;
          default: bs_pct = 100;
        endcase
      end
      cfg_write(CFG_DELAY, d);
      cfg_write(CFG_FEEDBACK, f);
      cfg_write(CFG_MIX, m);
      if (phase != 0 && $urandom_range(7, 0) == 0) begin
        cfg_write(CFG_ENABLE, 16'($urandom) & 16'hfffe);
      end else begin
        cfg_write(CFG_ENABLE, 16'($urandom) | 16'h0001);
      end
      for (int k = 0; k < n; k++) begin
        push_pair(rand_sample(), rand_sample(), $urandom_range(99, 0) < bs_pct);
      end
      total += n;
      phase++;
      drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && mix_q.size() == 0) begin
      $display("stereo_feedback_delay_core verification clean");
    end else begin
      $display("stereo_feedback_delay_core verification failed");
    end
    $finish;
  end

endmodule
